// ===== hdl/tts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle trapezoid split package
// Shared widths, payload types, queue entry layout and small helper
// functions for the triangle to trapezoid splitter.
// ----------------------------------------------------------------------------
package tts_pkg;

	// Coordinate format: signed fixed point, 8 fraction bits.
	localparam int COORD_BITS = 24;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int TOL_BITS   = 8;

	// Configuration port.
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 2;

	// Register byte addresses.
	localparam logic [APB_ADDR_BITS-1:0] ADDR_EQUAL_TOLERANCE = '0;

	// Queue between front end and back end.
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic [TOL_BITS-1:0]          tol_t;
	typedef logic [1:0]                   vid_t;

	// Vertex indices in input order.
	localparam vid_t VID_A = 2'd0;
	localparam vid_t VID_B = 2'd1;
	localparam vid_t VID_C = 2'd2;

	// One input transfer: three screen-space vertices.
	typedef struct packed {
		coord_t vertex_a_x;
		coord_t vertex_a_y;
		coord_t vertex_b_x;
		coord_t vertex_b_y;
		coord_t vertex_c_x;
		coord_t vertex_c_y;
	} vertex_t;

	// One result transfer: a trapezoid described by vertex indices.
	typedef struct packed {
		coord_t top_y;
		coord_t bottom_y;
		vid_t   left_start;
		vid_t   left_end;
		vid_t   right_start;
		vid_t   right_end;
		logic   last;
	} trap_t;

	// Triangle class decided by the front end.
	typedef enum logic [1:0] {
		KIND_FLAT_TOP,
		KIND_FLAT_BOTTOM,
		KIND_GENERAL
	} kind_t;

	// Queue entry: sorted, classified triangle ready for the back end.
	typedef struct packed {
		kind_t  kind;
		coord_t y_top;
		coord_t y_mid;
		coord_t y_bot;
		vid_t   id_top;
		vid_t   id_mid;
		vid_t   id_bot;
		diff_t  dx_mid;
		diff_t  dx_bot;
		diff_t  dy_mid;
		diff_t  dy_bot;
	} job_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic                 not_empty;
		logic [QCNT_BITS-1:0] count;
	} qstat_t;

	// True when two coordinates differ by at most tol LSBs.
	function automatic logic near_eq(input coord_t a, input coord_t b, input tol_t tol);
		diff_t                d;
		logic [DIFF_BITS-1:0] mag;
		d   = diff_t'(a) - diff_t'(b);
		mag = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
		return mag <= DIFF_BITS'(tol);
	endfunction

	// Select one of three coordinates by vertex index.
	function automatic coord_t pick(input coord_t v0, input coord_t v1, input coord_t v2,
			input vid_t id);
		coord_t r;
		case (id)
			VID_B: r = v1;
			VID_C: r = v2;
			default: r = v0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/tts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle trapezoid split front end
// Accepts triangles, drops degenerate ones, sorts the vertices by y and
// classifies each triangle before writing it into the queue.
// ----------------------------------------------------------------------------
module tts_front import tts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  vertex_t vertex,
	input  tol_t    tol,
	input  qstat_t  qstat,
	output logic    push,
	output job_t    job
);

	coord_t     xs [3];
	coord_t     ys [3];
	logic [2:0] gt [3];
	logic       degen;
	logic       accept;

	logic       valid_s1;
	coord_t     xs_s1 [3];
	coord_t     ys_s1 [3];
	logic [2:0] gt_s1 [3];

	vid_t       o0, o1, o2, tmp;

	logic       valid_s2;
	coord_t     sx_s2 [3];
	coord_t     sy_s2 [3];
	vid_t       sid_s2 [3];

	logic       flat_top, flat_bot, swap01, swap12;
	logic [QCNT_BITS:0] load;

	// Unpack the vertices and compare every ordered pair of y values.
	always_comb begin
		xs[0] = vertex.vertex_a_x;
		ys[0] = vertex.vertex_a_y;
		xs[1] = vertex.vertex_b_x;
		ys[1] = vertex.vertex_b_y;
		xs[2] = vertex.vertex_c_x;
		ys[2] = vertex.vertex_c_y;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				gt[i][j] = ys[i] > ys[j];
			end
		end
		degen = (near_eq(ys[0], ys[1], tol) && near_eq(ys[1], ys[2], tol)) ||
			(near_eq(xs[0], xs[1], tol) && near_eq(xs[1], xs[2], tol));
	end

	// Hold off new triangles once the queue plus the stages in flight could fill it.
	assign load = (QCNT_BITS+1)'(qstat.count) + (QCNT_BITS+1)'(valid_s1) +
		(QCNT_BITS+1)'(valid_s2);
	assign busy   = load >= (QCNT_BITS+1)'(QDEPTH);
	assign accept = start && !busy;

	// Stage 1: capture the vertices and pairwise order; degenerate triangles stop here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && !degen;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_s1 <= xs;
			ys_s1 <= ys;
			gt_s1 <= gt;
		end
	end

	// Three compare-and-swap steps on vertex indices, using the stored pair order.
	always_comb begin
		o0  = VID_A;
		o1  = VID_B;
		o2  = VID_C;
		tmp = VID_A;
		if (gt_s1[o0][o1]) begin
			tmp = o0; o0 = o1; o1 = tmp;
		end
		if (gt_s1[o0][o2]) begin
			tmp = o0; o0 = o2; o2 = tmp;
		end
		if (gt_s1[o1][o2]) begin
			tmp = o1; o1 = o2; o2 = tmp;
		end
	end

	// Stage 2: sorted vertices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sid_s2[0] <= o0;
			sid_s2[1] <= o1;
			sid_s2[2] <= o2;
			sx_s2[0]  <= pick(xs_s1[0], xs_s1[1], xs_s1[2], o0);
			sx_s2[1]  <= pick(xs_s1[0], xs_s1[1], xs_s1[2], o1);
			sx_s2[2]  <= pick(xs_s1[0], xs_s1[1], xs_s1[2], o2);
			sy_s2[0]  <= pick(ys_s1[0], ys_s1[1], ys_s1[2], o0);
			sy_s2[1]  <= pick(ys_s1[0], ys_s1[1], ys_s1[2], o1);
			sy_s2[2]  <= pick(ys_s1[0], ys_s1[1], ys_s1[2], o2);
		end
	end

	// Classify and order the flat pair by x, then build the queue entry.
	always_comb begin
		flat_top = near_eq(sy_s2[0], sy_s2[1], tol);
		flat_bot = near_eq(sy_s2[1], sy_s2[2], tol);
		swap01   = flat_top && (sx_s2[0] > sx_s2[1]);
		swap12   = !flat_top && flat_bot && (sx_s2[1] > sx_s2[2]);

		if (flat_top) begin
			job.kind = KIND_FLAT_TOP;
		end else if (flat_bot) begin
			job.kind = KIND_FLAT_BOTTOM;
		end else begin
			job.kind = KIND_GENERAL;
		end

		job.y_top  = swap01 ? sy_s2[1] : sy_s2[0];
		job.y_mid  = sy_s2[1];
		job.y_bot  = swap12 ? sy_s2[1] : sy_s2[2];
		job.id_top = swap01 ? sid_s2[1] : sid_s2[0];
		job.id_mid = swap01 ? sid_s2[0] : (swap12 ? sid_s2[2] : sid_s2[1]);
		job.id_bot = swap12 ? sid_s2[1] : sid_s2[2];

		// Edge vectors from the top vertex, used by the side test.
		job.dx_mid = diff_t'(sx_s2[1]) - diff_t'(sx_s2[0]);
		job.dx_bot = diff_t'(sx_s2[2]) - diff_t'(sx_s2[0]);
		job.dy_mid = diff_t'(sy_s2[1]) - diff_t'(sy_s2[0]);
		job.dy_bot = diff_t'(sy_s2[2]) - diff_t'(sy_s2[0]);
	end

	assign push = valid_s2;

	// A transfer is never taken while the front end reports busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !valid_s1 || $past(valid_s1) || $past(valid_s2) || $past(qstat.count != '0))
		else $error("stage 1 loaded while busy");

	// The sorted ids are a permutation of the three vertices.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (sid_s2[0] != sid_s2[1]) && (sid_s2[1] != sid_s2[2]) &&
			(sid_s2[0] != sid_s2[2]))
		else $error("sorted vertex ids collide");

	// Sorted y values are in ascending order.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (sy_s2[0] <= sy_s2[1]) && (sy_s2[1] <= sy_s2[2]))
		else $error("vertices not sorted by y");

endmodule

// ===== hdl/tts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle trapezoid split queue
// Short first-in first-out queue of classified triangles between the front
// end and the back end.
// ----------------------------------------------------------------------------
module tts_queue import tts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   job_in,
	input  logic   pop,
	output job_t   job_out,
	output qstat_t qstat
);

	job_t                 mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	assign job_out         = mem_q[rd_ptr_q];
	assign qstat.count     = count_q;
	assign qstat.not_empty = count_q != '0;

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_BITS'(QDEPTH)) || pop)
		else $error("queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue underflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with empty count");

endmodule

// ===== hdl/tts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle trapezoid split back end
// Takes classified triangles from the queue, runs the exact side test on
// the middle vertex and emits one or two trapezoids per triangle.
// ----------------------------------------------------------------------------
module tts_back import tts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  qstat_t qstat,
	input  job_t   job,
	output logic   pop,
	output logic   trap_valid,
	output trap_t  trap
);

	logic  valid_b1;
	job_t  job_b1;
	prod_t prod_l_b1;
	prod_t prod_r_b1;
	logic  phase_b1;

	logic  general;
	logic  release_b1;
	logic  free_b1;
	logic  mid_left;
	trap_t trap_next;

	logic  trap_valid_q;
	trap_t trap_q;

	// A general triangle holds the stage through both phases, all others through the first only.
	assign general    = job_b1.kind == KIND_GENERAL;
	assign release_b1 = valid_b1 && (!general || phase_b1);
	assign free_b1    = !valid_b1 || release_b1;
	assign pop        = qstat.not_empty && free_b1;

	// Stage b1: entry plus the two cross products of the side test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			phase_b1 <= 1'b0;
		end else if (free_b1) begin
			valid_b1 <= pop;
			phase_b1 <= 1'b0;
		end else begin
			phase_b1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_b1    <= job;
			prod_l_b1 <= prod_t'(job.dx_mid) * prod_t'(job.dy_bot);
			prod_r_b1 <= prod_t'(job.dx_bot) * prod_t'(job.dy_mid);
		end
	end

	// Middle vertex lies left of the long edge when its cross product is smaller.
	assign mid_left = prod_l_b1 < prod_r_b1;

	// Build the trapezoid for the current triangle and phase.
	always_comb begin
		trap_next.top_y       = job_b1.y_top;
		trap_next.bottom_y    = job_b1.y_bot;
		trap_next.left_start  = job_b1.id_top;
		trap_next.left_end    = job_b1.id_bot;
		trap_next.right_start = job_b1.id_top;
		trap_next.right_end   = job_b1.id_bot;
		trap_next.last        = 1'b1;
		unique case (job_b1.kind)
			KIND_FLAT_TOP: begin
				trap_next.right_start = job_b1.id_mid;
			end
			KIND_FLAT_BOTTOM: begin
				trap_next.left_end = job_b1.id_mid;
			end
			KIND_GENERAL: begin
				if (!phase_b1) begin
					// Upper part, from the top vertex down to the middle y.
					trap_next.bottom_y = job_b1.y_mid;
					trap_next.last     = 1'b0;
					if (mid_left) begin
						trap_next.left_end = job_b1.id_mid;
					end else begin
						trap_next.right_end = job_b1.id_mid;
					end
				end else begin
					// Lower part, from the middle y down to the bottom vertex.
					trap_next.top_y = job_b1.y_mid;
					if (mid_left) begin
						trap_next.left_start = job_b1.id_mid;
					end else begin
						trap_next.right_start = job_b1.id_mid;
					end
				end
			end
			default: begin
				trap_next.last = 1'b1;
			end
		endcase
	end

	// Output register: one result transfer per cycle while b1 holds a triangle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trap_valid_q <= 1'b0;
		end else begin
			trap_valid_q <= valid_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_b1) begin
			trap_q <= trap_next;
		end
	end

	assign trap_valid = trap_valid_q;
	assign trap       = trap_q;

	// The lower half of a split triangle follows its upper half at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		trap_valid && !trap.last |=> trap_valid && trap.last)
		else $error("second trapezoid missing");

	// Every edge joins two different vertices.
	assert property (@(posedge clk) disable iff (!arst_n)
		trap_valid |-> (trap.left_start != trap.left_end) &&
			(trap.right_start != trap.right_end))
		else $error("degenerate trapezoid edge");

	// The bottom bound never lies above the top bound.
	assert property (@(posedge clk) disable iff (!arst_n)
		trap_valid |-> trap.bottom_y >= trap.top_y)
		else $error("trapezoid bounds inverted");

endmodule

// ===== hdl/triangle_trapezoid_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle trapezoid split
// Splits a screen-space triangle into zero, one or two trapezoids whose
// edges are named by input vertex index.
// ----------------------------------------------------------------------------
// A triangle transfer is taken on any cycle with start high and busy low.
// Triangles flow through two front-end stages into a four-entry queue; busy
// rises once the queue plus the triangles still in the front end could fill
// it. The back end emits one trapezoid per cycle, so flat-top and flat-bottom
// triangles sustain one per cycle and split triangles hold stage b1 for both
// phases, the back end's output port being the limit. A triangle's first
// trapezoid goes through stage 1, stage 2, the queue, stage b1 and the
// output register; degenerate triangles give nothing. The receiver cannot
// stall: each trap_valid pulse lasts one cycle and must be taken then.
// ----------------------------------------------------------------------------
module triangle_trapezoid_split import tts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Command side
	input  logic                     start,
	output logic                     busy,
	input  vertex_t                  vertex,
	// Result side
	output logic                     trap_valid,
	output trap_t                    trap,
	// Configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	tol_t   tol_q;
	logic   push;
	logic   pop;
	job_t   job_push;
	job_t   job_pop;
	qstat_t qstat;
	logic   cfg_wr;

	// Configuration register; the only register sits at address zero.
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_EQUAL_TOLERANCE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_wr) begin
			tol_q <= pwdata[TOL_BITS-1:0];
		end
	end

	assign prdata = APB_DATA_BITS'(tol_q);
	assign pready = 1'b1;

	tts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.vertex (vertex),
		.tol    (tol_q),
		.qstat  (qstat),
		.push   (push),
		.job    (job_push)
	);

	tts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_push),
		.pop     (pop),
		.job_out (job_pop),
		.qstat   (qstat)
	);

	tts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.job        (job_pop),
		.pop        (pop),
		.trap_valid (trap_valid),
		.trap       (trap)
	);

endmodule
